// ===== src/blss_pkg.sv =====
`default_nettype none
package blss_pkg;

    // Defaults of the top-level parameters.
    localparam int BUFFER_DEPTH_DEF       = 2048;
    localparam int KERNEL_DEPTH_DEF       = 512;
    localparam int PHASE_BITS_DEF         = 6;
    localparam int TIME_FRACTION_BITS_DEF = 16;
    localparam int ACCUM_SAMPLE_BITS_DEF  = 30;
    localparam int GUARD_ENTRIES_DEF      = 16;

    // Depth of the queue between the front and the engine.
    localparam int FRONT_DEPTH = 4;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    // Input modes as they arrive on the port.
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_END  = 2'd2;
    localparam logic [1:0] MODE_READ = 2'd3;

    // Item classes handed from the front to the engine.
    localparam logic [2:0] K_NOP  = 3'd0;
    localparam logic [2:0] K_LOAD = 3'd1;
    localparam logic [2:0] K_ADD  = 3'd2;
    localparam logic [2:0] K_END  = 3'd3;
    localparam logic [2:0] K_READ = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_RATE_FACTOR = 2'd0;
    localparam logic [1:0] REG_LEAK_SHIFT  = 2'd1;
    localparam logic [1:0] REG_DELTA_SCALE = 2'd2;
    localparam logic [1:0] REG_WIDE_KERNEL = 2'd3;

    typedef struct packed {
        logic [31:0] rate_factor;
        logic [4:0]  leak_shift;
        logic [15:0] delta_scale;
        logic        wide_kernel;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         kind;
        logic [19:0]        clock_time;
        logic signed [15:0] step_delta;
        logic [8:0]         kernel_index;
        logic signed [15:0] kernel_word;
    } t_item;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               sample_valid;
        logic               overrun;
        logic [11:0]        samples_ready;
    } t_result;

endpackage
`default_nettype wire

// ===== src/blss_front.sv =====
`default_nettype none
module blss_front #(
    parameter int KERNEL_DEPTH = 512
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire [1:0]            i_mode,
    input  wire [19:0]           i_clock_time,
    input  wire signed [15:0]    i_step_delta,
    input  wire [8:0]            i_kernel_index,
    input  wire signed [15:0]    i_kernel_word,
    output logic                 o_full,
    output logic                 o_valid,
    output blss_pkg::t_item      o_item,
    input  wire                  i_pop
);
    import blss_pkg::*;

    localparam int PW = $clog2(FRONT_DEPTH);

    t_item            r_mem [FRONT_DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [PW:0]      r_cnt;
    t_item            w_item;

    // Classify on entry; a load beyond the kernel store becomes a no-op.
    always_comb begin
        w_item.clock_time   = i_clock_time;
        w_item.step_delta   = i_step_delta;
        w_item.kernel_index = i_kernel_index;
        w_item.kernel_word  = i_kernel_word;
        case (i_mode)
            MODE_LOAD: w_item.kind = (32'(i_kernel_index) < KERNEL_DEPTH) ? K_LOAD : K_NOP;
            MODE_ADD:  w_item.kind = K_ADD;
            MODE_END:  w_item.kind = K_END;
            MODE_READ: w_item.kind = K_READ;
            default:   w_item.kind = K_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    assign o_full  = (r_cnt == (PW+1)'(FRONT_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

endmodule
`default_nettype wire

// ===== src/blss_outq.sv =====
`default_nettype none
module blss_outq (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  blss_pkg::t_result    i_res,
    output logic                 o_full,
    output logic                 o_empty,
    input  wire                  i_pop,
    output blss_pkg::t_result    o_res
);
    import blss_pkg::*;

    t_result     r_mem [2];
    logic        r_wr, r_rd;
    logic [1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_mem[r_rd];

endmodule
`default_nettype wire

// ===== src/blss_engine.sv =====
`default_nettype none
module blss_engine #(
    parameter int BUFFER_DEPTH       = 2048,
    parameter int KERNEL_DEPTH       = 512,
    parameter int PHASE_BITS         = 6,
    parameter int TIME_FRACTION_BITS = 16,
    parameter int ACCUM_SAMPLE_BITS  = 30,
    parameter int GUARD_ENTRIES      = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  blss_pkg::t_cfg       i_cfg,
    input  wire                  i_item_valid,
    input  blss_pkg::t_item      i_item,
    output logic                 o_item_pop,
    output logic                 o_res_push,
    output blss_pkg::t_result    o_res,
    input  wire                  i_res_full,
    output logic                 o_clearing
);
    import blss_pkg::*;

    localparam int RW   = $clog2(BUFFER_DEPTH);
    localparam int KW   = $clog2(KERNEL_DEPTH);
    localparam int CAP  = BUFFER_DEPTH - GUARD_ENTRIES;
    localparam int PB   = PHASE_BITS;
    localparam int FB   = TIME_FRACTION_BITS;
    localparam int TAW  = (PB + 3 > KW) ? PB + 3 : KW;
    localparam int SHR  = ACCUM_SAMPLE_BITS - 16;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_END  = 4'd3;
    localparam logic [3:0] S_ADDT = 4'd4;
    localparam logic [3:0] S_HB   = 4'd5;
    localparam logic [3:0] S_TAP  = 4'd6;
    localparam logic [3:0] S_RD   = 4'd7;
    localparam logic [3:0] S_RD1  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [31:0]        r_ring [BUFFER_DEPTH];
    logic signed [15:0] r_kmem [KERNEL_DEPTH];

    logic [3:0]         r_state;
    logic [RW-1:0]      r_cnt;
    t_item              r_item;
    logic [31:0]        r_frame_offset, r_hpa, r_prod, r_t, r_rdata;
    logic signed [31:0] r_scaled;
    logic signed [15:0] r_kdata;
    logic [RW-1:0]      r_head;
    logic [RW:0]        r_hb;
    logic signed [15:0] r_sample;
    logic               r_valid, r_over;
    logic               r_p1_valid, r_p1_kzero, r_p2_valid;
    logic [RW-1:0]      r_p1_slot, r_p2_slot;
    logic [31:0]        r_tprod, r_racc;

    logic [51:0]        w_tmul;
    logic signed [31:0] w_scaled;
    logic [31:0]        w_t, w_whole, w_ready, w_s;
    logic [2:0]         w_half, w_k;
    logic [3:0]         w_first, w_j, w_pos, w_ntaps;
    logic               w_lo, w_issue, w_kzero;
    logic [PB-1:0]      w_ph;
    logic [TAW-1:0]     w_addr;
    logic [RW:0]        w_sum;
    logic [RW-1:0]      w_slot, w_ra;
    logic               w_we;
    logic [RW-1:0]      w_wa;
    logic [31:0]        w_wd;
    logic signed [15:0] w_sat;
    logic               w_kwe;

    assign w_tmul   = 52'(r_item.clock_time) * 52'(i_cfg.rate_factor);
    assign w_scaled = r_item.step_delta * $signed({1'b0, i_cfg.delta_scale});
    assign w_t      = r_prod + r_frame_offset;

    assign w_whole  = r_frame_offset >> FB;
    assign w_ready  = (w_whole <= 32'(CAP)) ? w_whole : 32'd0;

    // Tap decode: the first half walks the kernel upward from the phase,
    // the second half mirrors it.
    always_comb begin
        w_half  = i_cfg.wide_kernel ? 3'd6 : 3'd4;
        w_first = i_cfg.wide_kernel ? 4'd2 : 4'd4;
        w_ntaps = {w_half, 1'b0};
        w_j     = r_cnt[3:0];
        w_lo    = (w_j < {1'b0, w_half});
        w_k     = w_lo ? w_j[2:0] : 3'(w_j - {1'b0, w_half});
        w_pos   = w_lo ? (w_first + {1'b0, w_k}) : (4'd8 + {1'b0, w_k});
        w_ph    = r_t[FB-1 -: PB];
        if (w_lo) begin
            w_addr = TAW'(1 << PB) - TAW'(w_ph) + (TAW'(w_k) << PB);
        end else begin
            w_addr = TAW'(w_ph) + (TAW'(3'(w_half - 3'd1 - w_k)) << PB);
        end
        w_kzero = (32'(w_addr) >= KERNEL_DEPTH);
        w_sum   = r_hb + (RW+1)'(w_pos);
        w_slot  = (w_sum >= (RW+1)'(BUFFER_DEPTH)) ?
                  RW'(w_sum - (RW+1)'(BUFFER_DEPTH)) : w_sum[RW-1:0];
        w_issue = (r_state == S_TAP) && (w_j < w_ntaps);
    end

    // Sample output: arithmetic shift and saturation of the accumulator.
    always_comb begin
        w_s = 32'($signed(r_hpa) >>> SHR);
        if ((w_s[31:15] != '0) && (w_s[31:15] != '1)) begin
            w_sat = w_s[31] ? SAMPLE_MIN : SAMPLE_MAX;
        end else begin
            w_sat = w_s[15:0];
        end
    end

    // Single ring write port: clearing pass, tap accumulation, read clear.
    always_comb begin
        w_we = 1'b0;
        w_wa = r_head;
        w_wd = '0;
        if (r_state == S_CLR) begin
            w_we = 1'b1;
            w_wa = r_cnt;
        end else if (r_p2_valid) begin
            w_we = 1'b1;
            w_wa = r_p2_slot;
            w_wd = r_racc + r_tprod;
        end else if (r_state == S_RD1) begin
            w_we = 1'b1;
        end
    end

    assign w_ra       = (r_state == S_TAP) ? w_slot : r_head;
    assign o_item_pop = (r_state == S_IDLE) && i_item_valid;
    assign w_kwe      = o_item_pop && (i_item.kind == K_LOAD);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_ring[w_wa] <= w_wd;
        end
        r_rdata <= r_ring[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_kwe) begin
            r_kmem[KW'(i_item.kernel_index)] <= i_item.kernel_word;
        end
        r_kdata <= r_kmem[w_addr[KW-1:0]];
    end

    // Tap pipeline payload.
    always_ff @(posedge i_clk) begin
        r_p1_slot  <= w_slot;
        r_p1_kzero <= w_kzero;
        r_p2_slot  <= r_p1_slot;
        r_racc     <= r_rdata;
        r_tprod    <= r_p1_kzero ? 32'd0 : 32'(r_kdata * r_scaled);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLR;
            r_cnt          <= '0;
            r_frame_offset <= '0;
            r_hpa          <= '0;
            r_head         <= '0;
            r_p1_valid     <= 1'b0;
            r_p2_valid     <= 1'b0;
        end else begin
            r_p1_valid <= w_issue;
            r_p2_valid <= r_p1_valid;
            case (r_state)
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == RW'(BUFFER_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_item   <= i_item;
                        r_sample <= '0;
                        r_valid  <= 1'b0;
                        r_over   <= 1'b0;
                        case (i_item.kind)
                            K_ADD, K_END: r_state <= S_MUL;
                            K_READ:       r_state <= (w_ready != '0) ? S_RD : S_DONE;
                            default:      r_state <= S_DONE;
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod   <= w_tmul[31:0];
                    r_scaled <= w_scaled;
                    r_state  <= (r_item.kind == K_END) ? S_END : S_ADDT;
                end
                S_END: begin
                    r_frame_offset <= w_t;
                    r_state        <= S_DONE;
                end
                S_ADDT: begin
                    r_t <= w_t;
                    if (32'(w_t >> FB) >= 32'(CAP)) begin
                        r_over  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_hb    <= (RW+1)'(r_head) + (RW+1)'(w_t[FB +: RW]);
                        r_state <= S_HB;
                    end
                end
                S_HB: begin
                    if (r_hb >= (RW+1)'(BUFFER_DEPTH)) begin
                        r_hb <= r_hb - (RW+1)'(BUFFER_DEPTH);
                    end
                    r_cnt   <= '0;
                    r_state <= S_TAP;
                end
                S_TAP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_j == w_ntaps + 4'd1) begin
                        r_state <= S_DONE;
                    end
                end
                S_RD: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_sample       <= w_sat;
                    r_valid        <= 1'b1;
                    r_hpa          <= r_hpa + r_rdata
                                      - 32'($signed(r_hpa) >>> i_cfg.leak_shift);
                    r_head         <= (r_head == RW'(BUFFER_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    r_frame_offset <= r_frame_offset - (32'd1 << FB);
                    r_state        <= S_DONE;
                end
                S_DONE: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_push          = (r_state == S_DONE) && !i_res_full;
    assign o_res.sample        = r_sample;
    assign o_res.sample_valid  = r_valid;
    assign o_res.overrun       = r_over;
    assign o_res.samples_ready = w_ready[11:0];
    assign o_clearing          = (r_state == S_CLR);

endmodule
`default_nettype wire

// ===== src/band_limited_step_synth_buffer.sv =====
`default_nettype none
// Band-limited step synthesizer with a 32-bit sample accumulation ring.
// Words enter through a queue (push/full) and every word yields exactly one
// result word on the output queue (empty/pop), in order. After reset the
// ring is cleared one entry per cycle (BUFFER_DEPTH entries, 2048 by default);
// full stays high during the clearing pass while configuration
// writes are still taken. The engine handles one word at a time, and all
// ring writes go through a single write port; an accepted add walks eight
// kernel taps, or twelve with the wide kernel. A four-word input queue and
// a two-word result queue let the producer and the consumer run ahead of
// the engine. Kernel entries must be written before an add uses them.
module band_limited_step_synth_buffer #(
    parameter int BUFFER_DEPTH       = blss_pkg::BUFFER_DEPTH_DEF,
    parameter int KERNEL_DEPTH       = blss_pkg::KERNEL_DEPTH_DEF,
    parameter int PHASE_BITS         = blss_pkg::PHASE_BITS_DEF,
    parameter int TIME_FRACTION_BITS = blss_pkg::TIME_FRACTION_BITS_DEF,
    parameter int ACCUM_SAMPLE_BITS  = blss_pkg::ACCUM_SAMPLE_BITS_DEF,
    parameter int GUARD_ENTRIES      = blss_pkg::GUARD_ENTRIES_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [1:0]          i_cfg_index,
    input  wire [31:0]         i_cfg_data,
    input  wire                push,
    output logic               full,
    input  wire [1:0]          i_mode,
    input  wire [19:0]         i_clock_time,
    input  wire signed [15:0]  i_step_delta,
    input  wire [8:0]          i_kernel_index,
    input  wire signed [15:0]  i_kernel_word,
    output logic               empty,
    input  wire                pop,
    output logic signed [15:0] o_sample,
    output logic               o_sample_valid,
    output logic               o_overrun,
    output logic [11:0]        o_samples_ready
);
    import blss_pkg::*;

    t_cfg     r_cfg;
    t_item    w_item;
    t_result  w_eng_res, w_out_res;
    logic     w_front_full, w_item_valid, w_item_pop;
    logic     w_res_push, w_res_full, w_clearing;
    logic     w_push_ok, w_pop_ok;

    // Configuration registers; the port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_factor <= 32'h7FFF_FFFF;
            r_cfg.leak_shift  <= 5'd31;
            r_cfg.delta_scale <= '0;
            r_cfg.wide_kernel <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RATE_FACTOR: r_cfg.rate_factor <= i_cfg_data;
                REG_LEAK_SHIFT:  r_cfg.leak_shift  <= i_cfg_data[4:0];
                REG_DELTA_SCALE: r_cfg.delta_scale <= i_cfg_data[15:0];
                REG_WIDE_KERNEL: r_cfg.wide_kernel <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The input queue refuses words until the ring clearing pass is over.
    assign full      = w_front_full || w_clearing;
    assign w_push_ok = push && !full;
    assign w_pop_ok  = pop && !empty;

    blss_front #(
        .KERNEL_DEPTH (KERNEL_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (w_push_ok),
        .i_mode         (i_mode),
        .i_clock_time   (i_clock_time),
        .i_step_delta   (i_step_delta),
        .i_kernel_index (i_kernel_index),
        .i_kernel_word  (i_kernel_word),
        .o_full         (w_front_full),
        .o_valid        (w_item_valid),
        .o_item         (w_item),
        .i_pop          (w_item_pop)
    );

    blss_engine #(
        .BUFFER_DEPTH       (BUFFER_DEPTH),
        .KERNEL_DEPTH       (KERNEL_DEPTH),
        .PHASE_BITS         (PHASE_BITS),
        .TIME_FRACTION_BITS (TIME_FRACTION_BITS),
        .ACCUM_SAMPLE_BITS  (ACCUM_SAMPLE_BITS),
        .GUARD_ENTRIES      (GUARD_ENTRIES)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .o_res_push   (w_res_push),
        .o_res        (w_eng_res),
        .i_res_full   (w_res_full),
        .o_clearing   (w_clearing)
    );

    blss_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_eng_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_pop   (w_pop_ok),
        .o_res   (w_out_res)
    );

    assign o_sample        = w_out_res.sample;
    assign o_sample_valid  = w_out_res.sample_valid;
    assign o_overrun       = w_out_res.overrun;
    assign o_samples_ready = w_out_res.samples_ready;

    // A word is either a produced sample or a dropped add, never both.
    a_valid_vs_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_sample_valid && o_overrun))
        else $error("sample and overrun flagged on one word");

    // A word without a sample carries a zero sample.
    a_idle_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_sample_valid) |-> (o_sample == '0))
        else $error("nonzero sample on a word without a sample");

    // Nothing is taken in while the ring is being cleared.
    a_no_push_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !w_push_ok)
        else $error("word accepted during the clearing pass");

    // The result queue is empty right after every reset edge.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

endmodule
`default_nettype wire
